/* hdl/otb_pkg.sv */
package otb_pkg;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_RUN,
		ST_DRAIN,
		ST_RD,
		ST_BIN,
		ST_P,
		ST_Q,
		ST_D,
		ST_DEN,
		ST_L,
		ST_R,
		ST_FIN
	} otb_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} otb_mul_stat_t;

	localparam logic       ACT_HIST = 1'b0;
	localparam logic       ACT_BIN  = 1'b1;
	localparam logic       KIND_THR = 1'b0;
	localparam logic       KIND_PIX = 1'b1;
	localparam logic [7:0] LEVEL_HI = 8'd255;
	localparam logic [7:0] LEVEL_LO = 8'd0;

endpackage

/* hdl/otb_ram.sv */
module otb_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 22
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-old on a same-address collision
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/otb_mul.sv */
module otb_mul import otb_pkg::*; #(
	parameter int AW = 196,
	parameter int BW = 68
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output otb_mul_stat_t stat,
	output logic [AW-1:0] prod
);

	logic [AW-1:0] acc_q;
	logic [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic          busy_q;
	logic          done_q;

	// shift-add, one multiplier bit per cycle, ends when the rest of b is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

endmodule

/* hdl/otsu_threshold_binarizer.sv */
// channel | dir | beat fields (tdata / tuser / tlast)
// s_*     | in  | tdata[7:0] pixel ; tuser action ; tlast frame_last
// m_*     | out | tdata[7:0] level ; tuser kind
//
// Histogram and binarize beats are taken one per cycle outside a search; a
// bin update is a read-modify-write on the bin memory, forwarding the bin
// just written. A frame_last histogram beat starts a sweep of all LEVELS
// bins that also zeroes them, plus six shift-add multiplies (one bit a
// cycle, length set by the multiplier operand) for each candidate bin.
// After reset a clearing pass over all LEVELS bins runs before s_tready rises.
// A held m_tready stalls input through the single output register.
module otsu_threshold_binarizer import otb_pkg::*; #(
	parameter int LEVELS     = 256,
	parameter int COUNT_BITS = 22
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] pixel
	input  logic       s_tuser,   // [0] action
	input  logic       s_tlast,   // frame_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] level
	output logic       m_tuser    // [0] kind
);

	localparam int LB   = $clog2(LEVELS);
	localparam int NW   = COUNT_BITS + LB;     // pixel counts
	localparam int SW   = NW + LB;             // level sums
	localparam int PW   = NW + SW;             // s1*n0, s0*n1
	localparam int NUMW = 2 * PW;              // squared difference
	localparam int DENW = 2 * NW;              // n0*n1
	localparam int CW   = NUMW + DENW;         // cross products

	localparam logic [COUNT_BITS-1:0] CAP  = '1;
	localparam logic [LB-1:0]         LAST = LB'(LEVELS - 1);

	otb_state_t state_q, state_d;

	// accumulate pipeline
	logic                  acc_v_s1;
	logic [LB-1:0]         acc_idx_s1;
	logic                  fwd_v_q;
	logic [LB-1:0]         fwd_idx_q;
	logic [COUNT_BITS-1:0] fwd_cnt_q;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  bump;

	// memory ports
	logic                  mem_we;
	logic [LB-1:0]         mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic [LB-1:0]         mem_raddr;
	logic [COUNT_BITS-1:0] mem_rdata;

	// search
	logic [LB-1:0]   idx_q;
	logic [NW-1:0]   tot_n_q, n1_q, n1_n, n0, n0_n;
	logic [SW-1:0]   tot_s_q, s1_q, s1_n, s0;
	logic            stop_q, eval, issued_q;
	logic [PW-1:0]   p_q, q_q, d;
	logic [NUMW-1:0] num_q, bnum_q;
	logic [DENW-1:0] den_q, bden_q;
	logic [CW-1:0]   lhs_q;
	logic [7:0]      best_t_q, thr_q;

	// multiplier
	logic          mul_start;
	logic [CW-1:0] mul_a;
	logic [PW-1:0] mul_b;
	otb_mul_stat_t mul_stat;
	logic [CW-1:0] mul_prod;
	logic          mul_state;

	// handshake
	logic       out_free, in_acc, out_load;
	logic       m_tvalid_q, m_kind_q;
	logic [7:0] m_level_q, out_level;
	logic       out_kind;
	logic [LB-1:0] pix_idx;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_RUN) && out_free;
	assign in_acc   = s_tvalid && s_tready;

	// pixels beyond the bins land in the top bin
	assign pix_idx = ({24'd0, s_tdata} >= 32'(LEVELS)) ? LAST : LB'(s_tdata);

	assign cur_cnt = (fwd_v_q && fwd_idx_q == acc_idx_s1) ? fwd_cnt_q : mem_rdata;
	assign bump    = cur_cnt != CAP;
	assign new_cnt = bump ? cur_cnt + 1'b1 : cur_cnt;

	otb_ram #(.DEPTH(LEVELS), .WIDTH(COUNT_BITS)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	otb_mul #(.AW(CW), .BW(PW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.prod   (mul_prod)
	);

	// search arithmetic
	assign n0   = tot_n_q - n1_q;
	assign s0   = tot_s_q - s1_q;
	assign n1_n = n1_q + NW'(mem_rdata);
	assign s1_n = s1_q + SW'(idx_q) * SW'(mem_rdata);
	assign n0_n = tot_n_q - n1_n;
	assign eval = !stop_q && n1_n != '0;
	assign d    = (p_q >= q_q) ? p_q - q_q : q_q - p_q;

	assign mul_state = state_q == ST_P || state_q == ST_Q || state_q == ST_D ||
		state_q == ST_DEN || state_q == ST_L || state_q == ST_R;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (idx_q == LAST) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (in_acc && s_tuser == ACT_HIST && s_tlast) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_RD;
			ST_RD:    state_d = ST_BIN;
			ST_BIN: begin
				if (eval && n0_n != '0) state_d = ST_P;
				else if (idx_q == LAST) state_d = ST_FIN;
				else state_d = ST_RD;
			end
			ST_P:   if (mul_stat.done) state_d = ST_Q;
			ST_Q:   if (mul_stat.done) state_d = ST_D;
			ST_D:   if (mul_stat.done) state_d = ST_DEN;
			ST_DEN: if (mul_stat.done) state_d = ST_L;
			ST_L:   if (mul_stat.done) state_d = ST_R;
			ST_R: begin
				if (mul_stat.done) state_d = (idx_q == LAST) ? ST_FIN : ST_RD;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_RUN;
			end
			default: state_d = ST_CLR;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = acc_idx_s1;
		mem_wdata = new_cnt;
		mem_raddr = pix_idx;
		mul_start = mul_state && !issued_q;
		mul_a     = '0;
		mul_b     = '0;
		out_load  = 1'b0;
		out_kind  = KIND_PIX;
		out_level = (s_tdata > thr_q) ? LEVEL_HI : LEVEL_LO;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = '0;
			end
			ST_RUN, ST_DRAIN: begin
				mem_we   = acc_v_s1;
				out_load = in_acc && s_tuser == ACT_BIN;
			end
			ST_RD: begin
				// read the bin and zero it in the same cycle
				mem_raddr = idx_q;
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = '0;
			end
			ST_P: begin
				mul_a = CW'(s1_q);
				mul_b = PW'(n0);
			end
			ST_Q: begin
				mul_a = CW'(s0);
				mul_b = PW'(n1_q);
			end
			ST_D: begin
				mul_a = CW'(d);
				mul_b = d;
			end
			ST_DEN: begin
				mul_a = CW'(n0);
				mul_b = PW'(n1_q);
			end
			ST_L: begin
				mul_a = CW'(num_q);
				mul_b = PW'(bden_q);
			end
			ST_R: begin
				mul_a = CW'(bnum_q);
				mul_b = PW'(den_q);
			end
			ST_FIN: begin
				out_load  = out_free;
				out_kind  = KIND_THR;
				out_level = best_t_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			idx_q      <= '0;
			acc_v_s1   <= 1'b0;
			fwd_v_q    <= 1'b0;
			tot_n_q    <= '0;
			tot_s_q    <= '0;
			stop_q     <= 1'b0;
			issued_q   <= 1'b0;
			thr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			acc_v_s1 <= in_acc && s_tuser == ACT_HIST && s_tdata != 8'd0;
			fwd_v_q  <= acc_v_s1;
			if (acc_v_s1 && bump) begin
				tot_n_q <= tot_n_q + 1'b1;
				tot_s_q <= tot_s_q + SW'(acc_idx_s1);
			end
			if (mul_start) issued_q <= 1'b1;
			else if (mul_stat.done) issued_q <= 1'b0;
			case (state_q)
				ST_CLR: idx_q <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
				ST_DRAIN: begin
					idx_q  <= '0;
					stop_q <= 1'b0;
				end
				ST_BIN: begin
					if (eval && n0_n == '0) stop_q <= 1'b1;
					if (!(eval && n0_n != '0) && idx_q != LAST) idx_q <= idx_q + 1'b1;
				end
				ST_R: begin
					if (mul_stat.done && idx_q != LAST) idx_q <= idx_q + 1'b1;
				end
				ST_FIN: begin
					if (out_free) begin
						thr_q   <= best_t_q;
						tot_n_q <= '0;
						tot_s_q <= '0;
					end
				end
				default: begin
				end
			endcase
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		acc_idx_s1 <= pix_idx;
		fwd_idx_q  <= acc_idx_s1;
		fwd_cnt_q  <= new_cnt;
		if (out_load) begin
			m_level_q <= out_level;
			m_kind_q  <= out_kind;
		end
		case (state_q)
			ST_DRAIN: begin
				n1_q     <= '0;
				s1_q     <= '0;
				bnum_q   <= '0;
				bden_q   <= DENW'(1);
				best_t_q <= '0;
			end
			ST_BIN: begin
				n1_q <= n1_n;
				s1_q <= s1_n;
			end
			ST_P:   if (mul_stat.done) p_q   <= PW'(mul_prod);
			ST_Q:   if (mul_stat.done) q_q   <= PW'(mul_prod);
			ST_D:   if (mul_stat.done) num_q <= NUMW'(mul_prod);
			ST_DEN: if (mul_stat.done) den_q <= DENW'(mul_prod);
			ST_L:   if (mul_stat.done) lhs_q <= mul_prod;
			ST_R: begin
				// strictly greater keeps the first best threshold
				if (mul_stat.done && lhs_q > mul_prod) begin
					bnum_q   <= num_q;
					bden_q   <= den_q;
					best_t_q <= 8'(idx_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_level_q;
	assign m_tuser  = m_kind_q;

	a_no_acc_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN && state_q != ST_DRAIN) |-> !acc_v_s1)
		else $error("bin update pending during search");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && m_tvalid_q) |-> m_tready)
		else $error("output register overwritten");

	a_mul_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier started while busy");

	a_sweep_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> (idx_q == '0 && state_q == ST_RD))
		else $error("search sweep does not start at bin zero");

endmodule

/* dv/otb_checker.sv */
`timescale 1ns / 1ps

module otb_checker import otb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tuser,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tuser,
	output int         fail_count,
	output int         pending
);

	localparam int NBINS     = 256;
	localparam int CNT_W     = 22;
	localparam int WIDE      = 256;

	typedef struct packed {
		logic       kind;
		logic [7:0] level;
	} result_beat_t;

	logic [CNT_W-1:0] hist [NBINS];
	logic [7:0]       cur_thr;
	result_beat_t     result_q [$];

	// exact Otsu search, variances compared by cross-multiplication
	function automatic logic [7:0] find_otsu_level();
		int              lo, hi;
		logic [WIDE-1:0] tot_n, tot_s, n1, s1, n0, s0;
		logic [WIDE-1:0] p, q, d, num, den, bnum, bden;
		logic [7:0]      best;
		lo = -1; hi = -1;
		tot_n = '0; tot_s = '0; n1 = '0; s1 = '0;
		best = '0;
		for (int i = 0; i < NBINS; i++) begin
			if (hist[i] != 0) begin
				if (lo < 0) lo = i;
				hi = i;
				tot_n += hist[i];
				tot_s += WIDE'(i) * hist[i];
			end
		end
		if (lo < 0) return '0;
		bnum = '0;
		bden = WIDE'(1);
		for (int i = lo; i <= hi; i++) begin
			n1 += hist[i];
			s1 += WIDE'(i) * hist[i];
			n0 = tot_n - n1;
			s0 = tot_s - s1;
			if (n1 == 0 || n0 == 0) break;
			p = s1 * n0;
			q = s0 * n1;
			d = (p >= q) ? p - q : q - p;
			num = d * d;
			den = n0 * n1;
			if (num * bden > bnum * den) begin
				bnum = num;
				bden = den;
				best = i[7:0];
			end
		end
		return best;
	endfunction

	assign pending = result_q.size();

	initial begin
		fail_count = 0;
		cur_thr = '0;
		foreach (hist[i]) hist[i] = '0;
	end

	always @(posedge clk) begin
		result_beat_t want;
		result_beat_t next_beat;
		if (arst_n) begin
			// output side first: a beat taken this edge cannot answer one
			// accepted on the same edge
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t: result beat kind=%0b level=%0d with none expected",
						$time, m_tuser, m_tdata);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (m_tuser !== want.kind) begin
						$display("%0t: kind expected %0b actual %0b",
							$time, want.kind, m_tuser);
						fail_count++;
					end
					if (m_tdata !== want.level) begin
						$display("%0t: level expected %0d actual %0d",
							$time, want.level, m_tdata);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_BIN) begin
					next_beat.kind  = KIND_PIX;
					next_beat.level = (s_tdata > cur_thr) ? LEVEL_HI : LEVEL_LO;
					result_q.insert(result_q.size(), next_beat);
				end else begin
					// zero pixels stay out of the histogram
					if (s_tdata != 0 && hist[s_tdata] != {CNT_W{1'b1}})
						hist[s_tdata] = hist[s_tdata] + 1'b1;
					if (s_tlast) begin
						cur_thr = find_otsu_level();
						foreach (hist[i]) hist[i] = '0;
						next_beat.kind  = KIND_THR;
						next_beat.level = cur_thr;
						result_q.insert(result_q.size(), next_beat);
					end
				end
			end
		end
	end

endmodule

/* dv/tb_otsu_threshold_binarizer.sv */
`timescale 1ns / 1ps

module tb_otsu_threshold_binarizer;
	import otb_pkg::*;

	// cycles with no beat on either side before giving up; a frame search
	// over sparse small histograms runs well under this
	localparam int STALL_LIMIT = 400000;
	localparam int PIXEL_ITEMS = 1650;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] pixel
	logic       s_tuser;   // [0] action
	logic       s_tlast;   // frame_last
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] level
	logic       m_tuser;   // [0] kind

	int fail_count;
	int pending;
	int burst_left;
	int sent;
	int idle_cycles;
	bit long_hold;     // raised by the stimulus, taken by the receiver

	otsu_threshold_binarizer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	otb_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: stall patterns change every so often; a requested long
	// hold keeps tready low so the output register backs up into s_tready
	initial begin
		int mode, seg, hold;
		m_tready = 1'b0;
		mode = 0; seg = 0; hold = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				hold = 300;
			end
			if (seg == 0) begin
				mode = $urandom_range(0, 3);
				seg = $urandom_range(20, 200);
			end
			seg--;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 1) != 0);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// watchdog on beat progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("otsu_threshold_binarizer test failed");
			$finish;
		end
	end

	// one beat, held until taken; the burst may then end in a gap
	task automatic send_beat(input logic act, input logic [7:0] px, input logic lst);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= px;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			// mix long gapless bursts with short choppy ones
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 10);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// one histogram frame, pixels drawn from a random window of levels
	task automatic send_frame();
		int len, lo, hi;
		logic [7:0] px;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
		lo = $urandom_range(0, 255);
		hi = ($urandom_range(0, 3) == 0) ? 255 : lo + $urandom_range(0, 60);
		if (hi > 255) hi = 255;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				px = '0;
			else
				px = 8'($urandom_range(lo, hi));
			send_beat(ACT_HIST, px, i == len - 1);
		end
	endtask

	task automatic send_binarize_run(input int len);
		for (int i = 0; i < len; i++)
			send_beat(ACT_BIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int held;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		long_hold = 1'b0;
		idle_cycles = 0;
		sent = 0;
		burst_left = 8;
		held = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// binarize against the reset threshold, frame_last ignored there
		send_beat(ACT_BIN, 8'd0, 1'b0);
		send_beat(ACT_BIN, 8'd255, 1'b0);
		send_beat(ACT_BIN, 8'd1, 1'b1);
		// empty histogram: only a zero pixel
		send_beat(ACT_HIST, 8'd0, 1'b1);
		// single occupied level
		send_beat(ACT_HIST, 8'd100, 1'b0);
		send_beat(ACT_HIST, 8'd100, 1'b0);
		send_beat(ACT_HIST, 8'd100, 1'b1);
		drain_results();
		// two clusters, top bin included
		send_beat(ACT_HIST, 8'd10, 1'b0);
		send_beat(ACT_HIST, 8'd10, 1'b0);
		send_beat(ACT_HIST, 8'd200, 1'b0);
		send_beat(ACT_HIST, 8'd0, 1'b0);
		send_beat(ACT_HIST, 8'd255, 1'b1);
		send_beat(ACT_BIN, 8'd9, 1'b0);
		send_beat(ACT_BIN, 8'd10, 1'b0);
		send_beat(ACT_BIN, 8'd11, 1'b0);
		send_beat(ACT_BIN, 8'd255, 1'b0);
		// only zeros and the top level
		send_beat(ACT_HIST, 8'd0, 1'b0);
		send_beat(ACT_HIST, 8'd255, 1'b0);
		send_beat(ACT_HIST, 8'd255, 1'b1);
		send_beat(ACT_BIN, 8'd254, 1'b0);
		send_beat(ACT_BIN, 8'd128, 1'b0);
		drain_results();

		while (sent < PIXEL_ITEMS) begin
			send_frame();
			if (!held && sent > 400) begin
				// back up the output while binarize beats keep coming
				held = 1;
				long_hold = 1'b1;
				send_binarize_run(60);
			end else begin
				send_binarize_run($urandom_range(3, 30));
			end
			if ($urandom_range(0, 3) == 0)
				drain_results();
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("otsu_threshold_binarizer test passed");
		else
			$display("otsu_threshold_binarizer test failed");
		$finish;
	end

endmodule
